// ===== hdl/ap2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ap2d_pkg: shared types and constants for the 2-D average pooling block
// Field widths, register map, FSM state type and controller/datapath links.
// ----------------------------------------------------------------------------
package ap2d_pkg;

	// default parameter values
	localparam int DEF_MAX_HEIGHT  = 64;
	localparam int DEF_MAX_WIDTH   = 64;
	localparam int DEF_MAX_KERNEL  = 8;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_COUNT_PAD   = 0;

	// item field widths
	localparam int OP_W      = 1;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int SAMPLE_W  = 16;
	localparam int AVERAGE_W = 16;
	localparam int CELLS_W   = 7;

	// window position: row * stride - pad + kernel offset, signed
	localparam int POS_W = 12;
	// width for comparing row/col against the memory bounds
	localparam int LIM_W = 13;

	// opcodes
	localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
	localparam logic [OP_W-1:0] OP_EMIT = 1'b1;

	// configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KERNEL_H  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KERNEL_W  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE_H  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE_W  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PAD_TOP   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_PAD_LEFT  = 3'd7;

	typedef struct packed {
		logic [6:0] in_height;
		logic [6:0] in_width;
		logic [3:0] kernel_h;
		logic [3:0] kernel_w;
		logic [3:0] stride_h;
		logic [3:0] stride_w;
		logic [2:0] pad_top;
		logic [2:0] pad_left;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		in_height: 7'd64,
		in_width:  7'd64,
		kernel_h:  4'd2,
		kernel_w:  4'd2,
		stride_h:  4'd1,
		stride_w:  4'd1,
		pad_top:   3'd0,
		pad_left:  3'd0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DIV_INIT,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic mem_wr;
		logic win_start;
		logic win_step;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic win_empty;
		logic win_last;
		logic div_last;
	} sts_t;

endpackage

// ===== hdl/ap2d_feed_if.sv =====
// ----------------------------------------------------------------------------
// ap2d_feed_if: input channel of the average pooling block
// Carries load and emit items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ap2d_feed_if;
	logic                              valid;
	logic                              ready;
	logic [ap2d_pkg::OP_W-1:0]         op;
	logic [ap2d_pkg::ROW_W-1:0]        row;
	logic [ap2d_pkg::COL_W-1:0]        col;
	logic signed [ap2d_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, op, row, col, sample, input ready);
	modport sink   (input valid, op, row, col, sample, output ready);
endinterface

// ===== hdl/ap2d_result_if.sv =====
// ----------------------------------------------------------------------------
// ap2d_result_if: output channel of the average pooling block
// Carries one window average per emit item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ap2d_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ap2d_pkg::AVERAGE_W-1:0] average;
	logic [ap2d_pkg::CELLS_W-1:0]          cells_used;

	modport source (output valid, average, cells_used, input ready);
	modport sink   (input valid, average, cells_used, output ready);
endinterface

// ===== hdl/average_pool_2d.sv =====
// ----------------------------------------------------------------------------
// average_pool_2d: two-dimensional average pooling over one stored plane
// Top level: config registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   feed channel: op = load writes sample at (row, col) of the plane memory;
//   op = emit computes the average of the window for output (row, col).
//   result channel: one item (average, cells_used) per emit, none per load.
//   APB port: geometry registers at byte offsets 0x00..0x1C; write only while
//   no emit is in flight.
// Sequence:
//   A load is written in the idle state. An emit walks the kernel_h*kernel_w
//   window cells (none when a kernel dimension is zero), drains the read pipe,
//   then divides; SUM_W = SAMPLE_BITS + bits of the cell count (23 with
//   defaults) is the dividend width. The next item is taken once the result
//   is in the output register. The single memory read port (one window cell
//   per cycle) and the one bit per cycle restoring divider pace each emit.
// Reset: registers return to their defaults, the controller goes idle and no
//   result is pending; the plane memory is not cleared and must be loaded.
// Stall: a finished result sits in the output register until taken; loads
//   are still accepted meanwhile, and a following emit waits before handoff.
// ----------------------------------------------------------------------------
module average_pool_2d #(
	parameter int MAX_HEIGHT  = ap2d_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH   = ap2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL  = ap2d_pkg::DEF_MAX_KERNEL,
	parameter int SAMPLE_BITS = ap2d_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_PAD   = ap2d_pkg::DEF_COUNT_PAD
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ap2d_feed_if.sink                   feed,
	ap2d_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ap2d_pkg::APB_AW-1:0] paddr,
	input  logic [ap2d_pkg::APB_DW-1:0] pwdata,
	output logic [ap2d_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	ap2d_pkg::cfg_t cfg;
	ap2d_pkg::cmd_t cmd;
	ap2d_pkg::sts_t sts;
	logic           feed_ready;
	logic           res_valid;

	// configuration registers
	ap2d_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	ap2d_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (feed.valid),
		.feed_op    (feed.op),
		.feed_ready (feed_ready),
		.res_ready  (result.ready),
		.res_valid  (res_valid),
		.cmd        (cmd),
		.sts        (sts)
	);

	// memory, accumulator and divider
	ap2d_dp #(
		.MAX_HEIGHT  (MAX_HEIGHT),
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_KERNEL  (MAX_KERNEL),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_PAD   (COUNT_PAD)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.feed_row    (feed.row),
		.feed_col    (feed.col),
		.feed_sample (feed.sample),
		.cmd         (cmd),
		.sts         (sts),
		.average     (result.average),
		.cells_used  (result.cells_used)
	);

	assign feed.ready   = feed_ready;
	assign result.valid = res_valid;

endmodule

// ===== hdl/ap2d_regs.sv =====
// ----------------------------------------------------------------------------
// ap2d_regs: configuration register file
// APB-style write/read of the eight geometry registers, 4-byte spaced.
// ----------------------------------------------------------------------------
module ap2d_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ap2d_pkg::APB_AW-1:0]   paddr,
	input  logic [ap2d_pkg::APB_DW-1:0]   pwdata,
	output logic [ap2d_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output ap2d_pkg::cfg_t                cfg
);

	ap2d_pkg::cfg_t                    cfg_q;
	logic [ap2d_pkg::REG_IDX_W-1:0]    idx;
	logic                              wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ap2d_pkg::APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ap2d_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				ap2d_pkg::REG_IN_HEIGHT: cfg_q.in_height <= pwdata[6:0];
				ap2d_pkg::REG_IN_WIDTH:  cfg_q.in_width  <= pwdata[6:0];
				ap2d_pkg::REG_KERNEL_H:  cfg_q.kernel_h  <= pwdata[3:0];
				ap2d_pkg::REG_KERNEL_W:  cfg_q.kernel_w  <= pwdata[3:0];
				ap2d_pkg::REG_STRIDE_H:  cfg_q.stride_h  <= pwdata[3:0];
				ap2d_pkg::REG_STRIDE_W:  cfg_q.stride_w  <= pwdata[3:0];
				ap2d_pkg::REG_PAD_TOP:   cfg_q.pad_top   <= pwdata[2:0];
				ap2d_pkg::REG_PAD_LEFT:  cfg_q.pad_left  <= pwdata[2:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			ap2d_pkg::REG_IN_HEIGHT: prdata = {25'd0, cfg_q.in_height};
			ap2d_pkg::REG_IN_WIDTH:  prdata = {25'd0, cfg_q.in_width};
			ap2d_pkg::REG_KERNEL_H:  prdata = {28'd0, cfg_q.kernel_h};
			ap2d_pkg::REG_KERNEL_W:  prdata = {28'd0, cfg_q.kernel_w};
			ap2d_pkg::REG_STRIDE_H:  prdata = {28'd0, cfg_q.stride_h};
			ap2d_pkg::REG_STRIDE_W:  prdata = {28'd0, cfg_q.stride_w};
			ap2d_pkg::REG_PAD_TOP:   prdata = {29'd0, cfg_q.pad_top};
			ap2d_pkg::REG_PAD_LEFT:  prdata = {29'd0, cfg_q.pad_left};
		endcase
	end

endmodule

// ===== hdl/ap2d_dp.sv =====
// ----------------------------------------------------------------------------
// ap2d_dp: pooling datapath
// Plane memory, window walker, accumulator, restoring divider, result reg.
// ----------------------------------------------------------------------------
module ap2d_dp #(
	parameter int MAX_HEIGHT  = ap2d_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH   = ap2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL  = ap2d_pkg::DEF_MAX_KERNEL,
	parameter int SAMPLE_BITS = ap2d_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_PAD   = ap2d_pkg::DEF_COUNT_PAD
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ap2d_pkg::cfg_t                         cfg,
	input  logic [ap2d_pkg::ROW_W-1:0]             feed_row,
	input  logic [ap2d_pkg::COL_W-1:0]             feed_col,
	input  logic signed [ap2d_pkg::SAMPLE_W-1:0]   feed_sample,
	input  ap2d_pkg::cmd_t                         cmd,
	output ap2d_pkg::sts_t                         sts,
	output logic signed [ap2d_pkg::AVERAGE_W-1:0]  average,
	output logic [ap2d_pkg::CELLS_W-1:0]           cells_used
);

	localparam int MEM_DEPTH = MAX_HEIGHT * MAX_WIDTH;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	// kernel registers are 4 bits, so the usable kernel never exceeds 15
	localparam int KMAX      = (MAX_KERNEL < 15) ? MAX_KERNEL : 15;
	localparam int HCAP      = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
	localparam int WCAP      = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
	localparam int CNT_W     = $clog2(KMAX * KMAX + 1);
	localparam int SUM_W     = SAMPLE_BITS + CNT_W;
	localparam int DC_W      = $clog2(SUM_W);
	localparam int P_W       = ap2d_pkg::POS_W;
	localparam int L_W       = ap2d_pkg::LIM_W;

	// plane memory
	logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];

	// window walker
	logic signed [P_W-1:0]  r0_q, c0_q;
	logic [3:0]             i_q, j_q;
	logic [3:0]             kh_eff, kw_eff;
	logic [6:0]             h_eff, w_eff;
	logic signed [P_W-1:0]  r_cur, c_cur;
	logic                   in_plane;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic                   wr_ok;
	logic [9:0]             r_prod, c_prod;
	logic [31:0]            sample_ext;

	// read pipe and accumulator
	logic                   rd_valid_s1;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]       used_q;

	// divider
	logic [SUM_W-1:0]       quo_q;
	logic [CNT_W-1:0]       rem_q;
	logic [CNT_W-1:0]       div_q;
	logic                   neg_q;
	logic                   div_zero_q;
	logic [DC_W-1:0]        dcnt_q;
	logic [CNT_W-1:0]       divisor;
	logic [7:0]             area;
	logic [CNT_W:0]         shifted;
	logic [CNT_W:0]         trial;
	logic [SUM_W-1:0]       sum_mag;

	// result shaping
	logic signed [SUM_W:0]        q_signed;
	logic [SAMPLE_BITS-1:0]       q_sat;
	logic                         fits;
	logic [63:0]                  q_ext;
	logic [15:0]                  used_ext;
	logic signed [ap2d_pkg::AVERAGE_W-1:0] average_q;
	logic [ap2d_pkg::CELLS_W-1:0]          cells_q;

	// effective geometry, saturated to what the build supports
	always_comb begin
		kh_eff = (cfg.kernel_h > 4'(KMAX)) ? 4'(KMAX) : cfg.kernel_h;
		kw_eff = (cfg.kernel_w > 4'(KMAX)) ? 4'(KMAX) : cfg.kernel_w;
		h_eff  = (cfg.in_height > 7'(HCAP)) ? 7'(HCAP) : cfg.in_height;
		w_eff  = (cfg.in_width > 7'(WCAP)) ? 7'(WCAP) : cfg.in_width;
	end

	// window origin from the emit item
	assign r_prod = 10'(feed_row) * 10'(cfg.stride_h);
	assign c_prod = 10'(feed_col) * 10'(cfg.stride_w);

	// current cell and plane test
	always_comb begin
		r_cur    = r0_q + $signed({8'd0, i_q});
		c_cur    = c0_q + $signed({8'd0, j_q});
		in_plane = !r_cur[P_W-1] && !c_cur[P_W-1]
			&& (r_cur[P_W-2:0] < {4'd0, h_eff})
			&& (c_cur[P_W-2:0] < {4'd0, w_eff});
		rd_addr  = AW'(AW'(r_cur[6:0]) * AW'(MAX_WIDTH) + AW'(c_cur[6:0]));
	end

	// load address and bounds
	always_comb begin
		wr_ok      = ({7'd0, feed_row} < L_W'(MAX_HEIGHT)) && ({7'd0, feed_col} < L_W'(MAX_WIDTH));
		wr_addr    = AW'(AW'(feed_row) * AW'(MAX_WIDTH) + AW'(feed_col));
		sample_ext = {{16{feed_sample[15]}}, feed_sample};
	end

	// status to controller
	always_comb begin
		sts.win_empty = (kh_eff == 4'd0) || (kw_eff == 4'd0);
		sts.win_last  = (i_q == kh_eff - 4'd1) && (j_q == kw_eff - 4'd1);
		sts.div_last  = (dcnt_q == '0);
	end

	// plane memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_ok) begin
			mem[wr_addr] <= sample_ext[SAMPLE_BITS-1:0];
		end
		if (cmd.win_step && in_plane) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// walker counters, read valid and divide counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			rd_valid_s1 <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			rd_valid_s1 <= cmd.win_step && in_plane;
			if (cmd.win_start) begin
				i_q <= '0;
				j_q <= '0;
			end else if (cmd.win_step) begin
				if (j_q == kw_eff - 4'd1) begin
					j_q <= '0;
					i_q <= i_q + 4'd1;
				end else begin
					j_q <= j_q + 4'd1;
				end
			end
			if (cmd.div_start) begin
				dcnt_q <= DC_W'(SUM_W - 1);
			end else if (cmd.div_step && dcnt_q != '0) begin
				dcnt_q <= dcnt_q - DC_W'(1);
			end
		end
	end

	// divisor and sum magnitude
	always_comb begin
		area    = {4'd0, kh_eff} * {4'd0, kw_eff};
		divisor = (COUNT_PAD != 0) ? area[CNT_W-1:0] : used_q;
		sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		shifted = {rem_q, quo_q[SUM_W-1]};
		trial   = shifted - {1'b0, div_q};
	end

	// origin, accumulator, divider and result registers
	always_ff @(posedge clk) begin
		if (cmd.win_start) begin
			r0_q   <= $signed({2'd0, r_prod}) - $signed({9'd0, cfg.pad_top});
			c0_q   <= $signed({2'd0, c_prod}) - $signed({9'd0, cfg.pad_left});
			sum_q  <= '0;
			used_q <= '0;
		end else if (rd_valid_s1) begin
			sum_q  <= sum_q + $signed({{CNT_W{rd_data_s1[SAMPLE_BITS-1]}}, rd_data_s1});
			used_q <= used_q + CNT_W'(1);
		end

		if (cmd.div_start) begin
			quo_q      <= sum_mag;
			rem_q      <= '0;
			div_q      <= divisor;
			neg_q      <= sum_q[SUM_W-1];
			div_zero_q <= (divisor == '0);
		end else if (cmd.div_step) begin
			if (!trial[CNT_W]) begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end

		if (cmd.out_load) begin
			average_q <= q_ext[ap2d_pkg::AVERAGE_W-1:0];
			cells_q   <= used_ext[ap2d_pkg::CELLS_W-1:0];
		end
	end

	// signed quotient, saturated to the sample range, fitted to 16 bits
	always_comb begin
		if (div_zero_q) begin
			q_signed = '0;
		end else if (neg_q) begin
			q_signed = -$signed({1'b0, quo_q});
		end else begin
			q_signed = $signed({1'b0, quo_q});
		end
		fits = (q_signed[SUM_W:SAMPLE_BITS-1] == '0) || (q_signed[SUM_W:SAMPLE_BITS-1] == '1);
		if (fits) begin
			q_sat = q_signed[SAMPLE_BITS-1:0];
		end else if (q_signed[SUM_W]) begin
			q_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			q_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		q_ext    = {{(64-SAMPLE_BITS){q_sat[SAMPLE_BITS-1]}}, q_sat};
		used_ext = 16'(used_q);
	end

	assign average    = average_q;
	assign cells_used = cells_q;

endmodule

// ===== hdl/ap2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// ap2d_ctrl: pooling controller
// Sequences load, window walk, divide and result handoff; owns handshakes.
// ----------------------------------------------------------------------------
module ap2d_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        feed_valid,
	input  logic [ap2d_pkg::OP_W-1:0]   feed_op,
	output logic                        feed_ready,
	input  logic                        res_ready,
	output logic                        res_valid,
	output ap2d_pkg::cmd_t              cmd,
	input  ap2d_pkg::sts_t              sts
);

	ap2d_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             feed_acc;
	logic             out_free;

	assign feed_acc = feed_valid && feed_ready;
	assign out_free = !out_valid_q || res_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ap2d_pkg::ST_IDLE: begin
				if (feed_valid && feed_op == ap2d_pkg::OP_EMIT) state_d = ap2d_pkg::ST_WALK;
			end
			ap2d_pkg::ST_WALK: begin
				if (sts.win_empty || sts.win_last) state_d = ap2d_pkg::ST_DRAIN;
			end
			ap2d_pkg::ST_DRAIN:    state_d = ap2d_pkg::ST_DIV_INIT;
			ap2d_pkg::ST_DIV_INIT: state_d = ap2d_pkg::ST_DIV;
			ap2d_pkg::ST_DIV: begin
				if (sts.div_last) state_d = ap2d_pkg::ST_DONE;
			end
			ap2d_pkg::ST_DONE: begin
				if (out_free) state_d = ap2d_pkg::ST_IDLE;
			end
			default: state_d = ap2d_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		feed_ready    = (state_q == ap2d_pkg::ST_IDLE);
		cmd.mem_wr    = 1'b0;
		cmd.win_start = 1'b0;
		cmd.win_step  = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			ap2d_pkg::ST_IDLE: begin
				cmd.mem_wr    = feed_valid && feed_op == ap2d_pkg::OP_LOAD;
				cmd.win_start = feed_valid && feed_op == ap2d_pkg::OP_EMIT;
			end
			ap2d_pkg::ST_WALK:     cmd.win_step  = !sts.win_empty;
			ap2d_pkg::ST_DRAIN:    ;
			ap2d_pkg::ST_DIV_INIT: cmd.div_start = 1'b1;
			ap2d_pkg::ST_DIV:      cmd.div_step  = 1'b1;
			ap2d_pkg::ST_DONE:     cmd.out_load  = out_free;
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ap2d_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || res_ready))
		else $error("result overwritten while still pending");

	// a new result only appears after the handoff state
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ap2d_pkg::ST_DONE))
		else $error("result valid rose outside handoff");

	// items are only taken in idle, and an emit always starts a walk
	a_emit_walks: assert property (@(posedge clk) disable iff (!arst_n)
		(feed_acc && feed_op == ap2d_pkg::OP_EMIT) |=> (state_q == ap2d_pkg::ST_WALK))
		else $error("emit item did not start a window walk");

	// divider is loaded exactly once before stepping
	a_div_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ap2d_pkg::ST_DIV && !cmd.div_start))
		else $error("divider sequence broken");

endmodule

// ===== bench/average_pool_2d_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// average_pool_2d_checker: scoreboard for the 2-D average pooling block
// Watches the feed, result and register channels, keeps its own copy of the
// plane and the geometry, predicts each window average and compares results.
// ----------------------------------------------------------------------------
module average_pool_2d_checker
	import ap2d_pkg::*;
#(
	parameter int MAX_H       = DEF_MAX_HEIGHT,
	parameter int MAX_W       = DEF_MAX_WIDTH,
	parameter int MAX_K       = DEF_MAX_KERNEL,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COUNT_PAD   = DEF_COUNT_PAD
) (
	input  logic              clk,
	input  logic              arst_n,
	ap2d_feed_if              feed,
	ap2d_result_if            result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                errors,
	output int                awaiting,
	output int                checked
);

	localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

	typedef struct packed {
		logic signed [AVERAGE_W-1:0] average;
		logic [CELLS_W-1:0]          cells_used;
	} window_avg_t;

	// mirror of the block's geometry and plane memory
	cfg_t                       geom;
	logic signed [SAMPLE_W-1:0] plane_copy [MAX_H*MAX_W];
	window_avg_t                pending_windows [$];
	int                         mismatch_total;
	int                         match_total;

	function automatic int clip(int v, int hi);
		return (v > hi) ? hi : v;
	endfunction

	// average over the in-plane cells of the window for output (orow, ocol)
	function automatic window_avg_t window_average(logic [ROW_W-1:0] orow,
		logic [COL_W-1:0] ocol);
		window_avg_t res;
		int          h, w, kh, kw, r0, c0, r, c, used;
		longint      total, divisor, quotient;
		h = clip(int'(geom.in_height), MAX_H);
		w = clip(int'(geom.in_width), MAX_W);
		kh = clip(int'(geom.kernel_h), MAX_K);
		kw = clip(int'(geom.kernel_w), MAX_K);
		r0 = int'(orow) * int'(geom.stride_h) - int'(geom.pad_top);
		c0 = int'(ocol) * int'(geom.stride_w) - int'(geom.pad_left);
		total = 0;
		used = 0;
		for (int i = 0; i < kh; i++) begin
			r = r0 + i;
			if (r >= 0 && r < h) begin
				for (int j = 0; j < kw; j++) begin
					c = c0 + j;
					if (c >= 0 && c < w) begin
						total += longint'(plane_copy[r*MAX_W + c]);
						used++;
					end
				end
			end
		end
		divisor = COUNT_PAD ? longint'(kh * kw) : longint'(used);
		// signed division truncates toward zero; no cells gives zero
		quotient = (divisor > 0) ? total / divisor : 0;
		if (quotient > SAMPLE_HI)
			quotient = SAMPLE_HI;
		if (quotient < SAMPLE_LO)
			quotient = SAMPLE_LO;
		res.average = AVERAGE_W'(quotient);
		res.cells_used = CELLS_W'(used);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		window_avg_t want;
		if (!arst_n) begin
			geom = CFG_RESET;
			pending_windows.delete();
			mismatch_total = 0;
			match_total = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[REG_IDX_W+1:2])
					REG_IN_HEIGHT: geom.in_height = pwdata[6:0];
					REG_IN_WIDTH:  geom.in_width  = pwdata[6:0];
					REG_KERNEL_H:  geom.kernel_h  = pwdata[3:0];
					REG_KERNEL_W:  geom.kernel_w  = pwdata[3:0];
					REG_STRIDE_H:  geom.stride_h  = pwdata[3:0];
					REG_STRIDE_W:  geom.stride_w  = pwdata[3:0];
					REG_PAD_TOP:   geom.pad_top   = pwdata[2:0];
					REG_PAD_LEFT:  geom.pad_left  = pwdata[2:0];
					default: ;
				endcase
			end

			// accepted feed item: store a sample or queue the predicted average
			if (feed.valid && feed.ready) begin
				if (feed.op == OP_LOAD) begin
					if (int'(feed.row) < MAX_H && int'(feed.col) < MAX_W)
						plane_copy[int'(feed.row)*MAX_W + int'(feed.col)] = feed.sample;
				end else begin
					pending_windows.push_back(window_average(feed.row, feed.col));
				end
			end

			// accepted result: compare with the oldest prediction
			if (result.valid && result.ready) begin
				if (pending_windows.size() == 0) begin
					$display("%0t: unexpected result average %0d cells_used %0d, none expected",
						$time, $signed(result.average), result.cells_used);
					mismatch_total++;
				end else begin
					want = pending_windows.pop_front();
					if (result.average !== want.average) begin
						$display("%0t: average mismatch: expected %0d, got %0d",
							$time, $signed(want.average), $signed(result.average));
						mismatch_total++;
					end
					if (result.cells_used !== want.cells_used) begin
						$display("%0t: cells_used mismatch: expected %0d, got %0d",
							$time, want.cells_used, result.cells_used);
						mismatch_total++;
					end
					match_total++;
				end
			end
		end
		errors <= mismatch_total;
		awaiting <= pending_windows.size();
		checked <= match_total;
	end

endmodule

// ===== bench/average_pool_2d_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// average_pool_2d_tb: testbench for the 2-D average pooling block
// Drives load/emit items and geometry writes with random idle gaps and result
// stalls; a checker beside the block predicts and compares every average.
// ----------------------------------------------------------------------------
module average_pool_2d_tb;
	import ap2d_pkg::*;

	localparam int PLANE_ROWS   = DEF_MAX_HEIGHT;
	localparam int PLANE_COLS   = DEF_MAX_WIDTH;
	localparam int KERNEL_CAP   = DEF_MAX_KERNEL;
	localparam int MAX_IDLE     = 12;
	localparam int ITEM_GOAL    = 450;
	localparam int EMIT_GOAL    = 60;
	localparam int SETTLE_GAP   = 8;
	localparam int DRAIN_CYCLES = 100;

	localparam logic [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [SAMPLE_W-1:0] MOST_POS = ~MOST_NEG;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic              pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	int                fail_count;
	int                awaiting;
	int                checked;

	ap2d_feed_if   feed_ch();
	ap2d_result_if result_ch();

	// stimulus bookkeeping: current geometry and cells holding a sample
	int geo [8];
	bit loaded [PLANE_ROWS*PLANE_COLS];
	int n_items, n_loads, n_emits, n_settings;
	int gap_max, stall_max;

	average_pool_2d uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.feed    (feed_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	average_pool_2d_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed_ch),
		.result   (result_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.errors   (fail_count),
		.awaiting (awaiting),
		.checked  (checked)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	initial begin
		#2000000;
		$display("%0t: timeout, items or results stopped moving", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stall before taking each item
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	function automatic int cap(int v, int hi);
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return MOST_NEG;
			1: return MOST_POS;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic int idle_span();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 4;
			default: return MAX_IDLE;
		endcase
	endfunction

	// output coordinate, mostly within the windows that touch the plane
	function automatic int emit_coord(int extent, int stride, int pad);
		int lim;
		lim = (stride == 0) ? 3 : (cap(extent, PLANE_ROWS) + pad) / stride + 1;
		lim = cap(lim, PLANE_ROWS - 1);
		if ($urandom_range(0, 6) == 0)
			return $urandom_range(0, PLANE_ROWS - 1);
		return $urandom_range(0, lim);
	endfunction

	task automatic apb_write(logic [REG_IDX_W-1:0] idx, int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		geo[idx] = value;
	endtask

	task automatic set_geometry(int h, int w, int kh, int kw, int sh, int sw, int pt, int pl);
		apb_write(REG_IN_HEIGHT, h);
		apb_write(REG_IN_WIDTH, w);
		apb_write(REG_KERNEL_H, kh);
		apb_write(REG_KERNEL_W, kw);
		apb_write(REG_STRIDE_H, sh);
		apb_write(REG_STRIDE_W, sw);
		apb_write(REG_PAD_TOP, pt);
		apb_write(REG_PAD_LEFT, pl);
		n_settings++;
	endtask

	// one feed item; valid stays high across back-to-back items
	task automatic put_item(logic [OP_W-1:0] op, int row, int col, logic [SAMPLE_W-1:0] sample);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			feed_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_ch.valid <= 1'b1;
		feed_ch.op <= op;
		feed_ch.row <= ROW_W'(row);
		feed_ch.col <= COL_W'(col);
		feed_ch.sample <= sample;
		do @(posedge clk); while (!feed_ch.ready);
		n_items++;
	endtask

	task automatic put_load(int row, int col, logic [SAMPLE_W-1:0] sample);
		put_item(OP_LOAD, row, col, sample);
		loaded[row*PLANE_COLS + col] = 1'b1;
		n_loads++;
	endtask

	task automatic put_emit(int orow, int ocol);
		int h, w, kh, kw, r0, c0;
		h = cap(geo[REG_IN_HEIGHT], PLANE_ROWS);
		w = cap(geo[REG_IN_WIDTH], PLANE_COLS);
		kh = cap(geo[REG_KERNEL_H], KERNEL_CAP);
		kw = cap(geo[REG_KERNEL_W], KERNEL_CAP);
		r0 = orow * geo[REG_STRIDE_H] - geo[REG_PAD_TOP];
		c0 = ocol * geo[REG_STRIDE_W] - geo[REG_PAD_LEFT];
		// every in-plane cell of the window must hold a sample first
		for (int r = r0; r < r0 + kh; r++)
			for (int c = c0; c < c0 + kw; c++)
				if (r >= 0 && r < h && c >= 0 && c < w && !loaded[r*PLANE_COLS + c])
					put_load(r, c, rand_sample());
		put_item(OP_EMIT, orow, ocol, rand_sample());
		n_emits++;
	endtask

	// stop sending until every average is back, then let a load finish
	task automatic settle();
		feed_ch.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	task automatic run_phase(int budget);
		int stop, h, w;
		stop = n_items + budget;
		h = cap(geo[REG_IN_HEIGHT], PLANE_ROWS);
		w = cap(geo[REG_IN_WIDTH], PLANE_COLS);
		while (n_items < stop) begin
			case ($urandom_range(0, 19))
				0, 1, 2: put_load($urandom_range(0, PLANE_ROWS - 1),
					$urandom_range(0, PLANE_COLS - 1), rand_sample());
				3, 4: put_load($urandom_range(0, (h > 0) ? h - 1 : 0),
					$urandom_range(0, (w > 0) ? w - 1 : 0), rand_sample());
				5: settle();
				default: put_emit(
					emit_coord(geo[REG_IN_HEIGHT], geo[REG_STRIDE_H], geo[REG_PAD_TOP]),
					emit_coord(geo[REG_IN_WIDTH], geo[REG_STRIDE_W], geo[REG_PAD_LEFT]));
			endcase
		end
		settle();
	endtask

	function automatic int pick_extent();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 127);
			1: return $urandom_range(1, PLANE_ROWS);
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_kernel();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
	endfunction

	// main sequence
	initial begin
		n_items = 0;
		n_loads = 0;
		n_emits = 0;
		n_settings = 0;
		gap_max = 0;
		stall_max = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		feed_ch.valid <= 1'b0;
		feed_ch.op <= OP_LOAD;
		feed_ch.row <= '0;
		feed_ch.col <= '0;
		feed_ch.sample <= '0;
		geo[REG_IN_HEIGHT] = int'(CFG_RESET.in_height);
		geo[REG_IN_WIDTH] = int'(CFG_RESET.in_width);
		geo[REG_KERNEL_H] = int'(CFG_RESET.kernel_h);
		geo[REG_KERNEL_W] = int'(CFG_RESET.kernel_w);
		geo[REG_STRIDE_H] = int'(CFG_RESET.stride_h);
		geo[REG_STRIDE_W] = int'(CFG_RESET.stride_w);
		geo[REG_PAD_TOP] = int'(CFG_RESET.pad_top);
		geo[REG_PAD_LEFT] = int'(CFG_RESET.pad_left);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset geometry: extreme samples, bottom-right corner,
		// and truncation toward zero for both signs
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < 2; c++)
				put_load(r, c, MOST_NEG);
		put_emit(0, 0);
		for (int r = 62; r < 64; r++)
			for (int c = 62; c < 64; c++)
				put_load(r, c, MOST_POS);
		put_emit(62, 62);
		put_emit(63, 63);
		for (int r = 10; r < 12; r++)
			for (int c = 10; c < 12; c++)
				put_load(r, c, (r == 10 && c == 10) ? SAMPLE_W'(3) : '0);
		put_emit(10, 10);
		for (int r = 20; r < 22; r++)
			for (int c = 20; c < 22; c++)
				put_load(r, c, (r == 20 && c == 20) ? SAMPLE_W'(-7) : '0);
		put_emit(20, 20);
		settle();

		// corner geometries: oversized plane and kernel with zero stride,
		// empty planes, zero kernel, smallest and largest windows
		gap_max = idle_span();
		stall_max = idle_span();
		set_geometry(127, 100, 15, 9, 0, 0, 7, 7);
		run_phase(20);
		set_geometry(0, 5, 3, 3, 1, 1, 0, 0);
		run_phase(12);
		set_geometry(7, 0, 3, 3, 2, 2, 1, 1);
		run_phase(12);
		set_geometry(1, 1, 0, 1, 1, 1, 0, 0);
		run_phase(12);
		gap_max = MAX_IDLE;
		stall_max = MAX_IDLE;
		set_geometry(1, 64, 1, 1, 1, 1, 0, 0);
		run_phase(12);
		set_geometry(64, 64, 8, 8, 8, 8, 7, 7);
		run_phase(40);

		// random geometries
		while (n_items < ITEM_GOAL || n_emits < EMIT_GOAL) begin
			gap_max = idle_span();
			stall_max = idle_span();
			set_geometry(pick_extent(), pick_extent(), pick_kernel(), pick_kernel(),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
				$urandom_range(0, 7), $urandom_range(0, 7));
			run_phase(30);
		end

		// drain
		feed_ch.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d loads and %0d emits over %0d geometry settings plus reset.",
			n_loads, n_emits, n_settings);
		$display("%0d averages checked with idle gaps and result stalls of 0 to %0d cycles.",
			checked, MAX_IDLE);
		if (awaiting != 0)
			$display("%0t: %0d expected averages never arrived", $time, awaiting);
		if (fail_count == 0 && awaiting == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
